// ===== hw/rtl/rflp_pkg.sv =====
// Package for the remote learn-and-press classifier: transaction types,
// command and status codes, register map and reset values.
// No dependencies.
package rflp_pkg;

  // Table size default and fixed field widths
  localparam int unsigned MAX_BUTTONS_DEF = 16;
  localparam int unsigned ES_W            = 5;   // entries_stored field
  localparam int unsigned EV_W            = 33;  // event_id field
  localparam int unsigned PADDR_W         = 4;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_HOLDOFF  = 2'd1;
  localparam logic [1:0] REG_LONG     = 2'd2;
  localparam logic [1:0] REG_RELEASE  = 2'd3;

  // Register reset values
  localparam logic [31:0] LEARN_TIMEOUT_RST = 32'd30000;
  localparam logic [31:0] HOLDOFF_RST       = 32'd500;
  localparam logic [31:0] LONG_PRESS_RST    = 32'd250;
  localparam logic [7:0]  RELEASE_POLLS_RST = 8'd5;

  localparam logic [7:0]  QUIET_MAX = 8'd255;

  typedef enum logic [1:0] {
    KIND_POLL   = 2'd0,
    KIND_LEARN  = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_DELETE = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    STAT_PRESS    = 4'd0,
    STAT_TIMEOUT  = 4'd1,
    STAT_LEARNED  = 4'd2,
    STAT_KNOWN    = 4'd3,
    STAT_FULL     = 4'd4,
    STAT_STARTED  = 4'd5,
    STAT_REFUSED  = 4'd6,
    STAT_DELETED  = 4'd7,
    STAT_MISSING  = 4'd8,
    STAT_CLEARED  = 4'd9
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic        code_valid;
    logic [31:0] code;
    logic [31:0] now_ms;
  } rflp_in_t;

  typedef struct packed {
    status_e          status;
    logic [EV_W-1:0]  event_id;
    logic             long_press;
    logic [ES_W-1:0]  entries_stored;
    logic             last;
  } rflp_out_t;

  typedef struct packed {
    logic [31:0] learn_timeout_ms;
    logic [31:0] holdoff_ms;
    logic [31:0] long_press_ms;
    logic [7:0]  release_polls;
  } rflp_cfg_t;

endpackage

// ===== hw/rtl/rflp_cfg.sv =====
// APB-style configuration register file for the classifier.
// Depends on rflp_pkg.
module rflp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rflp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output rflp_pkg::rflp_cfg_t          cfg_o
);
  import rflp_pkg::*;

  rflp_cfg_t cfg_q;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes, decoded on the word index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learn_timeout_ms <= LEARN_TIMEOUT_RST;
      cfg_q.holdoff_ms       <= HOLDOFF_RST;
      cfg_q.long_press_ms    <= LONG_PRESS_RST;
      cfg_q.release_polls    <= RELEASE_POLLS_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_TIMEOUT: cfg_q.learn_timeout_ms <= pwdata;
        REG_HOLDOFF: cfg_q.holdoff_ms       <= pwdata;
        REG_LONG:    cfg_q.long_press_ms    <= pwdata;
        REG_RELEASE: cfg_q.release_polls    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (paddr[3:2])
      REG_TIMEOUT: prdata = cfg_q.learn_timeout_ms;
      REG_HOLDOFF: prdata = cfg_q.holdoff_ms;
      REG_LONG:    prdata = cfg_q.long_press_ms;
      REG_RELEASE: prdata = {24'd0, cfg_q.release_polls};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/rf_remote_learn_and_press_classifier_core.sv =====
// Top level of the remote learn-and-press classifier: command sequencer,
// learned-code table memory, press tracking. Depends on rflp_pkg, rflp_cfg.
//
//   channel   handshake                 payload     direction
//   command   start_i / busy_o          cmd_i       in
//   result    res_strobe_o (1 cycle)    res_o       out
//   config    psel/penable/pwrite       paddr etc.  in (APB, pready tied high)
//
// A poll carrying a nonzero code, and a delete, sweep the code table through
// its single read port and then pass through the decide state; an item that
// gives two results also passes through ST_EMIT2. Other items go straight from
// accept to the decide state. busy_o holds off the next item until idle again.
// Reset is asynchronous and clears the mode, valid bits, count and press
// state; the table contents are only read behind a set valid bit.
// Results cannot be stalled; each is shown for exactly one cycle.
module rf_remote_learn_and_press_classifier_core #(
  parameter int unsigned MAX_BUTTONS = rflp_pkg::MAX_BUTTONS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command transaction
  input  logic                         start_i,
  output logic                         busy_o,
  input  rflp_pkg::rflp_in_t           cmd_i,
  // result transaction
  output logic                         res_strobe_o,
  output rflp_pkg::rflp_out_t          res_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rflp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import rflp_pkg::*;

  localparam int unsigned IDX_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BUTTONS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BUTTONS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT2
  } state_e;

  rflp_cfg_t cfg;

  rflp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Control and architectural state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] found_idx_q, found_idx_d;
  logic             free_q, free_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic             learning_q, learning_d;
  logic [MAX_BUTTONS-1:0] valid_q, valid_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [31:0]      held_q, held_d;
  logic [31:0]      pstart_q, pstart_d;
  logic [31:0]      pend_q, pend_d;
  logic             seen_q, seen_d;
  logic [7:0]       quiet_q, quiet_d;
  logic [31:0]      lstart_q, lstart_d;
  logic [31:0]      ldone_q, ldone_d;
  logic             out_vld_q, out_vld_d;
  rflp_out_t        out_q, out_d;

  // Latched item and flags evaluated at accept
  rflp_in_t item_q, item_d;
  logic     tmo_q, tmo_d;
  logic     hold_ok_q, hold_ok_d;
  logic     got_q, got_d;
  rflp_out_t res1_q, res1_d;

  // Code table memory
  logic [31:0]      mem [MAX_BUTTONS];
  logic             mem_re, mem_we;
  logic [IDX_W-1:0] mem_ra, mem_wa;
  logic [31:0]      mem_rdata_q;

  // Decide-cycle scratch
  logic [1:0]  nres;
  status_e     st0, st1;
  logic [EV_W-1:0] ev;
  logic        lng;
  logic [31:0] end_eff;
  logic [7:0]  quiet_eff;
  logic [31:0] dur;

  assign busy_o       = (state_q != ST_IDLE);
  assign res_strobe_o = out_vld_q;
  assign res_o        = out_q;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    learning_d  = learning_q;
    valid_d     = valid_q;
    count_d     = count_q;
    held_d      = held_q;
    pstart_d    = pstart_q;
    pend_d      = pend_q;
    seen_d      = seen_q;
    quiet_d     = quiet_q;
    lstart_d    = lstart_q;
    ldone_d     = ldone_q;
    out_vld_d   = 1'b0;
    out_d       = out_q;
    item_d      = item_q;
    tmo_d       = tmo_q;
    hold_ok_d   = hold_ok_q;
    got_d       = got_q;
    res1_d      = res1_q;
    mem_re      = 1'b0;
    mem_ra      = ptr_q[IDX_W-1:0];
    mem_we      = 1'b0;
    mem_wa      = free_idx_q;
    nres        = 2'd0;
    st0         = STAT_PRESS;
    st1         = STAT_PRESS;
    ev          = '0;
    lng         = 1'b0;
    end_eff     = pend_q;
    quiet_eff   = quiet_q;
    dur         = '0;

    unique case (state_q)
      // Latch the item and the time-window flags
      ST_IDLE: begin
        if (start_i) begin
          item_d    = cmd_i;
          tmo_d     = (cmd_i.now_ms - lstart_q) > cfg.learn_timeout_ms;
          hold_ok_d = (cmd_i.now_ms - ldone_q) >= cfg.holdoff_ms;
          got_d     = cmd_i.code_valid && (cmd_i.code != 32'd0);
          found_d   = 1'b0;
          free_d    = 1'b0;
          ptr_d     = '0;
          if ((cmd_i.kind == KIND_POLL && cmd_i.code_valid && cmd_i.code != 32'd0)
              || cmd_i.kind == KIND_DELETE) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DECIDE;
          end
        end
      end

      // Sweep the table: issue one read per cycle, compare in the next cycle
      ST_SCAN: begin
        if (rd_vld_q && !found_q && valid_q[rd_idx_q] && mem_rdata_q == item_q.code) begin
          found_d     = 1'b1;
          found_idx_d = rd_idx_q;
        end
        if (ptr_q < CNT_MAX) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = ptr_q[IDX_W-1:0];
          if (!free_q && !valid_q[ptr_q[IDX_W-1:0]]) begin
            free_d     = 1'b1;
            free_idx_d = ptr_q[IDX_W-1:0];
          end
          ptr_d = ptr_q + CNT_W'(1);
        end else if (!rd_vld_q) begin
          state_d = ST_DECIDE;
        end
      end

      // Apply the item to the state and form up to two results
      ST_DECIDE: begin
        case (item_q.kind)
          KIND_POLL: begin
            if (learning_q) begin
              if (tmo_q) begin
                learning_d = 1'b0;
                ldone_d    = item_q.now_ms;
                st0        = STAT_TIMEOUT;
                nres       = 2'd1;
              end
              if (got_q) begin
                if (found_q) begin
                  learning_d = 1'b0;
                  ldone_d    = item_q.now_ms;
                  st1        = STAT_KNOWN;
                end else if (count_q < CNT_MAX && free_q) begin
                  mem_we              = 1'b1;
                  valid_d[free_idx_q] = 1'b1;
                  count_d             = count_q + CNT_W'(1);
                  learning_d          = 1'b0;
                  ldone_d             = item_q.now_ms;
                  st1                 = STAT_LEARNED;
                end else begin
                  st1 = STAT_FULL;
                end
                // code result follows the timeout result if there was one
                if (nres == 2'd0) begin
                  st0 = st1;
                end
                nres = nres + 2'd1;
              end
            end else if (hold_ok_q) begin
              if (got_q) begin
                if (found_q) begin
                  if (held_q != item_q.code) begin
                    held_d   = item_q.code;
                    pstart_d = item_q.now_ms;
                    pend_d   = '0;
                  end
                  seen_d = 1'b1;
                end
              end else if (held_q != 32'd0) begin
                // first quiet poll latches release, later ones count
                if (seen_q) begin
                  end_eff = item_q.now_ms;
                  seen_d  = 1'b0;
                end else if (quiet_q < QUIET_MAX) begin
                  quiet_eff = quiet_q + 8'd1;
                end
                dur = end_eff - pstart_q;
                lng = dur >= cfg.long_press_ms;
                ev  = {1'b0, held_q} + (lng ? EV_W'(2) : EV_W'(1));
                if (quiet_eff >= cfg.release_polls) begin
                  held_d   = '0;
                  pstart_d = '0;
                  pend_d   = '0;
                  quiet_d  = '0;
                  ldone_d  = item_q.now_ms;
                  st0      = STAT_PRESS;
                  nres     = 2'd1;
                end else begin
                  pend_d  = end_eff;
                  quiet_d = quiet_eff;
                end
              end
            end
          end
          KIND_LEARN: begin
            if (count_q >= CNT_MAX) begin
              st0 = STAT_REFUSED;
            end else begin
              learning_d = 1'b1;
              lstart_d   = item_q.now_ms;
              st0        = STAT_STARTED;
            end
            nres = 2'd1;
          end
          KIND_CLEAR: begin
            valid_d = '0;
            count_d = '0;
            st0     = STAT_CLEARED;
            nres    = 2'd1;
          end
          default: begin
            if (found_q) begin
              valid_d[found_idx_q] = 1'b0;
              if (count_q != '0) begin
                count_d = count_q - CNT_W'(1);
              end
              st0 = STAT_DELETED;
            end else begin
              st0 = STAT_MISSING;
            end
            nres = 2'd1;
          end
        endcase

        out_d.status         = st0;
        out_d.event_id       = (st0 == STAT_PRESS) ? ev : '0;
        out_d.long_press     = (st0 == STAT_PRESS) ? lng : 1'b0;
        out_d.entries_stored = ES_W'(count_d);
        out_d.last           = (nres == 2'd1);
        out_vld_d            = (nres != 2'd0);

        res1_d.status         = st1;
        res1_d.event_id       = '0;
        res1_d.long_press     = 1'b0;
        res1_d.entries_stored = ES_W'(count_d);
        res1_d.last           = 1'b1;

        state_d = (nres == 2'd2) ? ST_EMIT2 : ST_IDLE;
      end

      // Second result of a learning poll
      ST_EMIT2: begin
        out_d     = res1_q;
        out_vld_d = 1'b1;
        state_d   = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State, control and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      found_q     <= 1'b0;
      found_idx_q <= '0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
      learning_q  <= 1'b0;
      valid_q     <= '0;
      count_q     <= '0;
      held_q      <= '0;
      pstart_q    <= '0;
      pend_q      <= '0;
      seen_q      <= 1'b0;
      quiet_q     <= '0;
      lstart_q    <= '0;
      ldone_q     <= '0;
      out_vld_q   <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      rd_vld_q    <= rd_vld_d;
      rd_idx_q    <= rd_idx_d;
      found_q     <= found_d;
      found_idx_q <= found_idx_d;
      free_q      <= free_d;
      free_idx_q  <= free_idx_d;
      learning_q  <= learning_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      held_q      <= held_d;
      pstart_q    <= pstart_d;
      pend_q      <= pend_d;
      seen_q      <= seen_d;
      quiet_q     <= quiet_d;
      lstart_q    <= lstart_d;
      ldone_q     <= ldone_d;
      out_vld_q   <= out_vld_d;
      out_q       <= out_d;
    end
  end

  // Item latch and second result, no reset needed
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    tmo_q     <= tmo_d;
    hold_ok_q <= hold_ok_d;
    got_q     <= got_d;
    res1_q    <= res1_d;
  end

  // Table memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= item_q.code;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= mem[mem_ra];
    end
  end

  // Checks
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CNT_W'($countones(valid_q)))
    else $error("stored count differs from number of valid entries");

  a_learning_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    learning_q |-> (count_q < CNT_MAX))
    else $error("learning mode with a full table");

  a_no_press_no_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == 32'd0) |-> (quiet_q == 8'd0))
    else $error("quiet poll count without a held code");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.last) |-> (state_q == ST_IDLE))
    else $error("final result while item still in progress");

  a_first_of_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.last) |=> (res_strobe_o && res_o.last))
    else $error("first of two results not followed by the final one");

endmodule
